@@ rtl/assert_macros.svh @@
// Shared assertion macros for the byte ring FIFO.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define BRFO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BRFO_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ rtl/brfo_pkg.sv @@
package brfo_pkg;

    // Ring geometry
    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = PTR_W + 1;

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LVL_W-1:0] lvl_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] write_data;
    } brfo_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_accepted;
        logic       dropped_oldest;
        logic [7:0] fill_level;
    } brfo_out_t;

    // Advance a pointer with wrap at the last slot
    function automatic ptr_t next_slot(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // Bytes held between read and write pointer
    function automatic lvl_t level_of(input ptr_t wp, input ptr_t rp);
        lvl_t l;
        if (wp >= rp) begin
            l = lvl_t'(wp) - lvl_t'(rp);
        end else begin
            l = LVL_W'(DEPTH) - lvl_t'(rp) + lvl_t'(wp);
        end
        return l;
    endfunction

endpackage

@@ rtl/brfo_ram.sv @@
module brfo_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8,
    parameter int WORDS  = 256
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/byte_ring_fifo_overwrite.sv @@
// An input transfer is registered in stage 1 along with the store read, then in the output register.
// Throughput: one item per cycle while the output is not stalled; the single-port-per-direction byte store and the
// pointer update both complete in the accept cycle.
// Reset (aresetn low, synchronous): pointers, block_reg and all valid flags clear.
// The byte store is not cleared; no clearing pass, items are taken right after reset.
`include "assert_macros.svh"

module byte_ring_fifo_overwrite
    import brfo_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  brfo_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output brfo_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    typedef struct packed {
        logic       read_valid;
        logic       write_accepted;
        logic       dropped_oldest;
        logic [7:0] fill_level;
    } s1_flags_t;

    logic      block_reg;
    ptr_t      wp_reg, wp_next;
    ptr_t      rp_reg, rp_next;
    logic      s1_valid_reg;
    s1_flags_t s1_reg, s1_next;
    logic      m_valid_reg;
    brfo_out_t m_data_reg;
    logic      in_xfer, load_out;
    logic      full, empty;
    logic      mem_we, mem_re;
    logic [7:0] mem_rdata;

    // Configuration: always ready, write while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_reg <= 1'b0;
        end else if (cfg_valid) begin
            block_reg <= cfg_data;
        end
    end

    // Handshake: input moves when stage 1 is empty or the result stage can advance
    assign load_out = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || load_out;
    assign in_xfer  = s_valid && s_ready;

    assign full  = (next_slot(wp_reg) == rp_reg);
    assign empty = (wp_reg == rp_reg);

    // Decode the item and update pointers
    always_comb begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        s1_next = '0;
        unique case (s_data.op)
            OP_PUSH: begin
                if (!(full && block_reg)) begin
                    if (full) begin
                        rp_next = next_slot(rp_reg);
                        s1_next.dropped_oldest = 1'b1;
                    end
                    mem_we  = in_xfer;
                    wp_next = next_slot(wp_reg);
                    s1_next.write_accepted = 1'b1;
                end
            end
            OP_POP: begin
                if (!empty) begin
                    mem_re  = in_xfer;
                    rp_next = next_slot(rp_reg);
                    s1_next.read_valid = 1'b1;
                end
            end
            OP_FLUSH: begin
                wp_next = '0;
                rp_next = '0;
            end
            default: begin
            end
        endcase
        s1_next.fill_level = 8'(level_of(wp_next, rp_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else if (in_xfer) begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    // Byte store
    brfo_ram #(
        .DATA_W (8),
        .ADDR_W (PTR_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (s_data.write_data),
        .re    (mem_re),
        .raddr (rp_reg),
        .rdata (mem_rdata)
    );

    // Stage 1: wait for the store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_reg <= s1_next;
        end
    end

    // Output register: hold until the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.read_data      <= s1_reg.read_valid ? mem_rdata : 8'd0;
            m_data_reg.read_valid     <= s1_reg.read_valid;
            m_data_reg.write_accepted <= s1_reg.write_accepted;
            m_data_reg.dropped_oldest <= s1_reg.dropped_oldest;
            m_data_reg.fill_level     <= s1_reg.fill_level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `BRFO_ASSERT(a_flush_clears, (in_xfer && s_data.op == OP_FLUSH) |=> (wp_reg == '0 && rp_reg == '0), "flush left a pointer set")
    `BRFO_ASSERT(a_empty_pop_holds, (in_xfer && s_data.op == OP_POP && empty) |=> $stable(rp_reg), "pop on empty moved the read pointer")
    `BRFO_ASSERT(a_stall_cause, (s1_valid_reg && !load_out) |-> (m_valid_reg && !m_ready), "stage 1 stalled with a free output")
    `BRFO_NEVER(a_flags_excl, m_valid_reg && m_data_reg.read_valid && m_data_reg.write_accepted, "result both read and wrote")

endmodule

@@ tb/sv/byte_ring_fifo_overwrite_test.sv @@
module byte_ring_fifo_overwrite_test;
    import brfo_pkg::*;

    // Op code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF        = 5;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int MAX_REPORTS     = 40;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    brfo_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    brfo_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    byte_ring_fifo_overwrite u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Shadow copy of the ring and its register
    logic [7:0] shadow_bytes [DEPTH];
    ptr_t       shadow_wr    = '0;
    ptr_t       shadow_rd    = '0;
    logic       shadow_block = 1'b0;
    brfo_out_t  expected_results [$];

    int send_idle_pct  = 15;
    int recv_idle_pct  = 73;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int items_sent     = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cfg_writes     = 0;
    int pushes_stored  = 0;
    int overwrites     = 0;
    int refused_pushes = 0;
    int pops_taken     = 0;
    int empty_pops     = 0;
    int flushes        = 0;
    int ignored_ops    = 0;

    function automatic ptr_t ring_advance(input ptr_t p);
        if (int'(p) == DEPTH - 1) begin
            return ptr_t'(0);
        end
        return ptr_t'(int'(p) + 1);
    endfunction

    function automatic int bytes_held();
        if (shadow_wr >= shadow_rd) begin
            return int'(shadow_wr) - int'(shadow_rd);
        end
        return DEPTH - int'(shadow_rd) + int'(shadow_wr);
    endfunction

    // Apply one accepted item to the shadow ring and queue its result
    function automatic void predict_fifo_item(input brfo_in_t item);
        brfo_out_t res;
        logic      full;
        res  = '0;
        full = (ring_advance(shadow_wr) == shadow_rd);
        case (item.op)
            OP_PUSH: begin
                if (full && shadow_block) begin
                    refused_pushes++;
                end else begin
                    if (full) begin
                        // drop the oldest byte to make room
                        shadow_rd = ring_advance(shadow_rd);
                        res.dropped_oldest = 1'b1;
                        overwrites++;
                    end
                    shadow_bytes[shadow_wr] = item.write_data;
                    shadow_wr = ring_advance(shadow_wr);
                    res.write_accepted = 1'b1;
                    pushes_stored++;
                end
            end
            OP_POP: begin
                if (shadow_wr != shadow_rd) begin
                    res.read_data  = shadow_bytes[shadow_rd];
                    res.read_valid = 1'b1;
                    shadow_rd = ring_advance(shadow_rd);
                    pops_taken++;
                end else begin
                    empty_pops++;
                end
            end
            OP_FLUSH: begin
                shadow_wr = '0;
                shadow_rd = '0;
                flushes++;
            end
            default: begin
                ignored_ops++;
            end
        endcase
        res.fill_level = 8'(bytes_held());
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_checked, what, got, want);
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        brfo_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending", int'(m_data), 0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_data.read_data != want.read_data)
                    report_mismatch("read_data", int'(m_data.read_data),
                                    int'(want.read_data));
                if (m_data.read_valid != want.read_valid)
                    report_mismatch("read_valid", int'(m_data.read_valid),
                                    int'(want.read_valid));
                if (m_data.write_accepted != want.write_accepted)
                    report_mismatch("write_accepted", int'(m_data.write_accepted),
                                    int'(want.write_accepted));
                if (m_data.dropped_oldest != want.dropped_oldest)
                    report_mismatch("dropped_oldest", int'(m_data.dropped_oldest),
                                    int'(want.dropped_oldest));
                if (m_data.fill_level != want.fill_level)
                    report_mismatch("fill_level", int'(m_data.fill_level),
                                    int'(want.fill_level));
            end
        end
    end

    // Drive result ready; hold it low for a long stretch on request
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL byte_ring_fifo_overwrite");
        $finish;
    end

    // Offer one item, idle first at random, and predict it on transfer
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        brfo_in_t item;
        int       gap;
        item.op         = op;
        item.write_data = data;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(6, 1);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_fifo_item(item);
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_block_mode(input logic mode);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_block = mode;
        cfg_writes++;
    endtask

    task automatic push_run(input int n);
        repeat (n) send_item(OP_PUSH, 8'($urandom));
    endtask

    task automatic pop_run(input int n);
        repeat (n) send_item(OP_POP, 8'($urandom));
    endtask

    // Push until full, then a few more against the full ring
    task automatic fill_to_full();
        push_run(DEPTH - 1 - bytes_held() + $urandom_range(4, 1));
    endtask

    task automatic test_directed_ops();
        send_item(OP_POP, 8'h00);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_PUSH, 8'hA5);
        send_item(OP_PUSH, 8'h5A);
        send_item(OP_UNUSED, 8'hFF);
        pop_run(4);
        send_item(OP_POP, 8'hFF);
        send_item(OP_PUSH, 8'h3C);
        send_item(OP_PUSH, 8'hC3);
        send_item(OP_FLUSH, 8'hFF);
        send_item(OP_POP, 8'h00);
        send_item(OP_PUSH, 8'h81);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_POP, 8'h00);
        send_item(OP_FLUSH, 8'h00);
    endtask

    // Mostly well-formed bursts with random content, some noise
    task automatic test_random_traffic(input logic mode, input int send_pct,
                                       input int recv_pct, input int count);
        int start;
        int pick;
        write_block_mode(mode);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        fill_to_full();
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                fill_to_full();
            end else if (pick < 34) begin
                push_run($urandom_range(12, 1));
            end else if (pick < 64) begin
                pop_run($urandom_range(12, 1));
            end else if (pick < 84) begin
                repeat ($urandom_range(8, 1)) send_item(2'($urandom_range(2)), 8'($urandom));
            end else if (pick < 92) begin
                pop_run(bytes_held() + 1);
            end else if (pick < 96) begin
                send_item(OP_FLUSH, 8'($urandom));
            end else begin
                send_item(OP_UNUSED, 8'($urandom));
            end
        end
    endtask

    // Stall the result side long enough to back up the input
    task automatic test_receiver_hold_off();
        write_block_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        fill_to_full();
        pop_run($urandom_range(40, 10));
        repeat (120) send_item(2'($urandom_range(2)), 8'($urandom));
        pop_run(bytes_held() + 1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_random_traffic(1'b0, 15, 73, 350);
        test_random_traffic(1'b1, 73, 15, 350);
        test_random_traffic(1'b0, 0, 0, 250);
        test_receiver_hold_off();

        wait_until_drained();
        repeat (6) @(posedge aclk);

        $display("ran %0d items, checked %0d results, %0d register writes in both full modes",
                 items_sent, results_checked, cfg_writes);
        $display(
            "stored %0d overwrote %0d refused %0d popped %0d empty %0d flushes %0d ignored %0d",
            pushes_stored, overwrites, refused_pushes, pops_taken, empty_pops,
            flushes, ignored_ops);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS byte_ring_fifo_overwrite");
        end else begin
            $display("FAIL byte_ring_fifo_overwrite");
        end
        $finish;
    end

endmodule
